>>> rtl/tpb_pkg.sv
// Shared constants, codes and fixed-point helpers of the ball and plate plant.
`timescale 1ns / 1ps
`default_nettype none

package tpb_pkg;

    localparam int SHRINK_ITERATIONS_DEF = 1024;

    // Configuration register indexes.
    localparam int          CFG_IDX_W         = 3;
    localparam logic [2:0]  CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0]  CFG_SAMPLE_RATE   = 3'd1;
    localparam logic [2:0]  CFG_ANGLE_MIN     = 3'd2;
    localparam logic [2:0]  CFG_ANGLE_MAX     = 3'd3;
    localparam logic [2:0]  CFG_POSITION_MIN  = 3'd4;
    localparam logic [2:0]  CFG_POSITION_MAX  = 3'd5;
    localparam logic [2:0]  CFG_SLOPE_GAIN    = 3'd6;
    localparam logic [2:0]  CFG_TILT_GAIN     = 3'd7;

    // Operation codes of an input item.
    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // Angle constants in Q16.16.
    localparam logic signed [31:0] TWO_PI_Q      = 32'sd411775;
    localparam logic signed [31:0] PI_Q          = 32'sd205887;
    localparam logic signed [31:0] HALF_PI_Q     = 32'sd102944;
    localparam logic signed [31:0] CORDIC_GAIN_Q = 32'sd39797;
    localparam int                 CORDIC_STEPS  = 16;

    // Reciprocal of two pi scaled by 2^33; applied to half the magnitude, taking bits 32 up.
    localparam logic signed [31:0] TWO_PI_RECIP  = 32'sd20860;

    // Failure bound factor: BASE + floor(SPAN * (N - iteration) / N), Q16.
    localparam logic [16:0] FAIL_BASE = 17'd13107;
    localparam logic [31:0] FAIL_SPAN = 32'd52429;
    localparam int          FAIL_W    = 17;

    // Widths of the reciprocal estimate correction.
    localparam int DIVD_W = 38;
    localparam int DIVS_W = 21;
    localparam int DIVQ_W = 16;

    function automatic logic signed [31:0] f_sat(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > 35'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Q16.16 product: drop 16 fraction bits rounding down, then saturate.
    function automatic logic signed [31:0] f_qsat(input logic signed [63:0] p);
        logic signed [31:0] res;
        if ((&p[63:47]) || !(|p[63:47])) begin
            res = p[47:16];
        end else if (p[63]) begin
            res = 32'sh8000_0000;
        end else begin
            res = 32'sh7FFF_FFFF;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] f_atan(input logic [3:0] i);
        logic signed [31:0] res;
        case (i)
            4'd0:    res = 32'sd51472;
            4'd1:    res = 32'sd30386;
            4'd2:    res = 32'sd16055;
            4'd3:    res = 32'sd8150;
            4'd4:    res = 32'sd4091;
            4'd5:    res = 32'sd2047;
            4'd6:    res = 32'sd1024;
            4'd7:    res = 32'sd512;
            4'd8:    res = 32'sd256;
            4'd9:    res = 32'sd128;
            4'd10:   res = 32'sd64;
            4'd11:   res = 32'sd32;
            4'd12:   res = 32'sd16;
            4'd13:   res = 32'sd8;
            4'd14:   res = 32'sd4;
            default: res = 32'sd2;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tpb_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none

interface tpb_cfg_if
    import tpb_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/tpb_in_if.sv
// Input item channel.
`timescale 1ns / 1ps
`default_nettype none

interface tpb_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] target_angle;
    logic signed [31:0] force_req;
    logic [31:0]        iteration;
    logic signed [31:0] init_position;
    logic signed [31:0] init_speed;
    logic signed [31:0] init_accel;
    logic signed [31:0] init_angle;
    logic signed [31:0] init_rate;
    logic signed [31:0] init_rate_change;

    modport source (output valid, op, target_angle, force_req, iteration, init_position,
                    init_speed, init_accel, init_angle, init_rate, init_rate_change,
                    input ready);
    modport sink   (input valid, op, target_angle, force_req, iteration, init_position,
                    init_speed, init_accel, init_angle, init_rate, init_rate_change,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/tpb_out_if.sv
// Result item channel.
`timescale 1ns / 1ps
`default_nettype none

interface tpb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] speed;
    logic signed [31:0] accel;
    logic signed [31:0] angle;
    logic signed [31:0] angle_rate;
    logic signed [31:0] angle_accel;
    logic               failed;

    modport source (output valid, position, speed, accel, angle, angle_rate, angle_accel,
                    failed, input ready);
    modport sink   (input valid, position, speed, accel, angle, angle_rate, angle_accel,
                    failed, output ready);
endinterface

`default_nettype wire

>>> rtl/tpb_mul.sv
// Shared 32 x 32 signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module tpb_mul (
    input  wire logic               i_clk,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic signed [63:0]      o_p
);
    logic signed [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

`default_nettype wire

>>> rtl/tpb_div.sv
// Quotient and remainder correction after a reciprocal estimate: one compare and subtract.
`timescale 1ns / 1ps
`default_nettype none

module tpb_div
    import tpb_pkg::*;
(
    input  wire logic [DIVD_W-1:0] i_num,
    input  wire logic [DIVD_W-1:0] i_prod,
    input  wire logic [DIVS_W-1:0] i_divisor,
    input  wire logic [DIVQ_W-1:0] i_qest,
    output logic [DIVQ_W-1:0]      o_quot,
    output logic [DIVS_W-1:0]      o_rem
);
    logic [DIVD_W-1:0] rem0;
    logic [DIVD_W-1:0] rem1;
    logic              fits;

    // The estimate is never high and at most one short, so one subtraction settles it.
    assign rem0   = i_num - i_prod;
    assign rem1   = rem0 - DIVD_W'(i_divisor);
    assign fits   = (rem0 >= DIVD_W'(i_divisor));
    assign o_quot = i_qest + DIVQ_W'(fits);
    assign o_rem  = fits ? rem1[DIVS_W-1:0] : rem0[DIVS_W-1:0];
endmodule

`default_nettype wire

>>> rtl/tpb_cordic.sv
// Rotation-mode CORDIC sine, one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none

module tpb_cordic
    import tpb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_angle,
    output logic                    o_busy,
    output logic signed [31:0]      o_sine
);
    logic signed [31:0] r_x, r_y, r_z;
    logic [3:0]         r_i;
    logic               r_busy;
    logic signed [31:0] dx, dy, at;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign at = f_atan(r_i);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
            r_x    <= CORDIC_GAIN_Q;
            r_y    <= '0;
            r_z    <= i_angle;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_i <= r_i + 4'd1;
            if (r_i == 4'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_sine = r_y;
endmodule

`default_nettype wire

>>> rtl/tilting_plate_ball_plant_step.sv
// Top level of the ball on a tilting plate plant: sequencer, state and configuration.
// One item is handled at a time; input ready is high only while the sequencer is idle.
// A load item sets the plant state and then the failure bounds; a step item also runs the
// plant update, whose longest part is the 16 micro-rotations of the CORDIC sine. All
// products go through one shared 32 x 32 multiplier with a registered output; the divisions
// by the iteration count and by two pi are a reciprocal product followed by a single
// compare and subtract. A finished result waits in an output register, so the next item
// may be accepted before the previous one is taken; the sequencer holds its finished item
// until that register is free.
// Configuration writes are always accepted and take effect at once.
`timescale 1ns / 1ps
`default_nettype none

module tilting_plate_ball_plant_step
    import tpb_pkg::*;
#(
    parameter int SHRINK_ITERATIONS = SHRINK_ITERATIONS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tpb_cfg_if.sink    i_cfg,
    tpb_in_if.sink     i_in,
    tpb_out_if.source  o_out
);
    localparam int ITER_W = $clog2(SHRINK_ITERATIONS + 1);
    // Span over the iteration count, scaled by 2^FAIL_RECIP_SH: the estimate is at most one short.
    localparam int          FAIL_RECIP_SH = $clog2(SHRINK_ITERATIONS) + 1;
    localparam logic [31:0] FAIL_RECIP    =
        32'((64'(FAIL_SPAN) << FAIL_RECIP_SH) / 64'(SHRINK_ITERATIONS));

    typedef enum logic [4:0] {
        ST_IDLE, ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6,
        ST_A0, ST_M1, ST_R1, ST_M2, ST_R2, ST_M3, ST_R3,
        ST_D0, ST_D1, ST_D2,
        ST_FOLD1, ST_FOLD2, ST_CS, ST_CW,
        ST_M4, ST_R4, ST_M5, ST_R5, ST_M6, ST_R6, ST_DONE
    } t_state;

    t_state r_state;

    // Configuration.
    logic [16:0]        r_cfg_period;
    logic [30:0]        r_cfg_rate;
    logic signed [31:0] r_amin, r_amax, r_pmin, r_pmax;
    logic [30:0]        r_slope, r_tilt;

    // Plant state.
    logic signed [31:0] r_pos, r_vel, r_acc, r_ang, r_rate, r_rchg;

    // Item and working registers.
    logic               r_op;
    logic signed [31:0] r_tgt, r_frc;
    logic [ITER_W-1:0]  r_diff;
    logic [DIVQ_W-1:0]  r_qe;
    logic [DIVD_W-1:0]  r_pf;
    logic [FAIL_W-1:0]  r_f;
    logic signed [31:0] r_lo, r_hi;
    logic signed [31:0] r_nang, r_nrate, r_nrchg, r_p2, r_nacc, r_nvel;
    logic signed [31:0] r_red;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_o_pos, r_o_vel, r_o_acc, r_o_ang, r_o_rate, r_o_rchg;
    logic               r_o_failed;

    // Shared units.
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [DIVD_W-1:0]  div_num;
    logic [DIVD_W-1:0]  div_prod;
    logic [DIVS_W-1:0]  div_divisor;
    logic [DIVQ_W-1:0]  div_quot;
    logic [DIVS_W-1:0]  div_rem;
    logic               cor_start, cor_busy;
    logic signed [31:0] cor_sine;

    logic               in_acc;
    logic [32:0]        ang_abs;
    logic signed [31:0] q_prod;
    logic signed [31:0] fold1, fold2;
    logic signed [31:0] pin_pos, pin_vel, pin_acc;
    logic               out_free;

    tpb_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    tpb_div u_div (
        .i_num     (div_num),
        .i_prod    (div_prod),
        .i_divisor (div_divisor),
        .i_qest    (r_qe),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    tpb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (r_red),
        .o_busy  (cor_busy),
        .o_sine  (cor_sine)
    );

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign q_prod      = f_qsat(mul_p);
    assign ang_abs     = r_nang[31] ? (33'd0 - {r_nang[31], r_nang}) : {r_nang[31], r_nang};

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_F0: begin
                mul_a = $signed(32'(r_diff));
                mul_b = $signed(FAIL_RECIP);
            end
            ST_F1: begin
                mul_a = $signed(FAIL_SPAN);
                mul_b = $signed(32'(r_diff));
            end
            ST_F2: begin
                mul_a = $signed(32'(r_qe));
                mul_b = $signed(32'(SHRINK_ITERATIONS));
            end
            ST_F4: begin
                mul_a = r_pmin;
                mul_b = $signed(32'(r_f));
            end
            ST_F5: begin
                mul_a = r_pmax;
                mul_b = $signed(32'(r_f));
            end
            ST_M1: begin
                mul_a = f_sat(35'(r_nang) - 35'(r_ang));
                mul_b = $signed({1'b0, r_cfg_rate});
            end
            ST_M2: begin
                mul_a = f_sat(35'(r_nrate) - 35'(r_rate));
                mul_b = $signed({1'b0, r_cfg_rate});
            end
            ST_M3: begin
                mul_a = $signed({1'b0, r_tilt});
                mul_b = r_nrchg;
            end
            ST_D0: begin
                mul_a = $signed(ang_abs[32:1]);
                mul_b = TWO_PI_RECIP;
            end
            ST_D1: begin
                mul_a = $signed(32'(mul_p[32 +: DIVQ_W]));
                mul_b = TWO_PI_Q;
            end
            ST_M4: begin
                mul_a = $signed({1'b0, r_slope});
                mul_b = cor_sine;
            end
            ST_M5: begin
                mul_a = r_nacc;
                mul_b = $signed(32'(r_cfg_period));
            end
            ST_M6: begin
                mul_a = r_nvel;
                mul_b = $signed(32'(r_cfg_period));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The correction serves the bound factor first, then the angle remainder.
    always_comb begin
        div_num     = DIVD_W'(ang_abs);
        div_prod    = mul_p[DIVD_W-1:0];
        div_divisor = DIVS_W'(TWO_PI_Q);
        if (r_state == ST_F3) begin
            div_num     = r_pf;
            div_divisor = DIVS_W'(SHRINK_ITERATIONS);
        end
    end

    assign cor_start = (r_state == ST_CS);

    // Wrap into [-pi, pi], then fold into [-pi/2, pi/2].
    always_comb begin
        fold1 = r_red;
        if (fold1 > PI_Q) begin
            fold1 = fold1 - TWO_PI_Q;
        end
        if (fold1 < -PI_Q) begin
            fold1 = fold1 + TWO_PI_Q;
        end
        fold2 = r_red;
        if (fold2 > HALF_PI_Q) begin
            fold2 = PI_Q - fold2;
        end
        if (fold2 < -HALF_PI_Q) begin
            fold2 = -PI_Q - fold2;
        end
    end

    // Position integration and the end stops; the right stop wins when inverted.
    always_comb begin
        pin_pos = f_sat(35'(q_prod) + 35'(r_pos));
        pin_vel = r_nvel;
        pin_acc = r_nacc;
        if (pin_pos <= r_pmin) begin
            pin_pos = r_pmin;
            pin_vel = '0;
            pin_acc = '0;
        end
        if (pin_pos >= r_pmax) begin
            pin_pos = r_pmax;
            pin_vel = '0;
            pin_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_pos        <= '0;
            r_vel        <= '0;
            r_acc        <= '0;
            r_ang        <= '0;
            r_rate       <= '0;
            r_rchg       <= '0;
            r_cfg_period <= 17'd655;
            r_cfg_rate   <= 31'd6553600;
            r_amin       <= -32'sd17157;
            r_amax       <= 32'sd17157;
            r_pmin       <= -32'sd32768;
            r_pmax       <= 32'sd32768;
            r_slope      <= 31'd459228;
            r_tilt       <= 31'd0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_SAMPLE_PERIOD: r_cfg_period <= i_cfg.data[16:0];
                    CFG_SAMPLE_RATE:   r_cfg_rate   <= i_cfg.data[30:0];
                    CFG_ANGLE_MIN:     r_amin       <= $signed(i_cfg.data);
                    CFG_ANGLE_MAX:     r_amax       <= $signed(i_cfg.data);
                    CFG_POSITION_MIN:  r_pmin       <= $signed(i_cfg.data);
                    CFG_POSITION_MAX:  r_pmax       <= $signed(i_cfg.data);
                    CFG_SLOPE_GAIN:    r_slope      <= i_cfg.data[30:0];
                    CFG_TILT_GAIN:     r_tilt       <= i_cfg.data[30:0];
                    default: ;
                endcase
            end

            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_in.op;
                        r_tgt <= i_in.target_angle;
                        r_frc <= i_in.force_req;
                        r_diff <= (i_in.iteration < 32'(SHRINK_ITERATIONS)) ?
                                  ITER_W'(32'(SHRINK_ITERATIONS) - i_in.iteration) : '0;
                        if (i_in.op == OP_LOAD) begin
                            r_pos  <= i_in.init_position;
                            r_vel  <= i_in.init_speed;
                            r_acc  <= i_in.init_accel;
                            r_ang  <= i_in.init_angle;
                            r_rate <= i_in.init_rate;
                            r_rchg <= i_in.init_rate_change;
                        end
                        r_state <= ST_F0;
                    end
                end
                ST_F0: r_state <= ST_F1;
                ST_F1: begin
                    r_qe    <= mul_p[FAIL_RECIP_SH +: DIVQ_W];
                    r_state <= ST_F2;
                end
                ST_F2: begin
                    r_pf    <= mul_p[DIVD_W-1:0];
                    r_state <= ST_F3;
                end
                ST_F3: begin
                    r_f     <= FAIL_BASE + FAIL_W'(div_quot);
                    r_state <= ST_F4;
                end
                ST_F4: r_state <= ST_F5;
                ST_F5: begin
                    r_lo    <= mul_p[47:16];
                    r_state <= ST_F6;
                end
                ST_F6: begin
                    r_hi    <= mul_p[47:16];
                    r_state <= (r_op == OP_LOAD) ? ST_DONE : ST_A0;
                end
                ST_A0: begin
                    r_nang  <= (r_tgt < r_amin) ? r_amin :
                               ((r_tgt > r_amax) ? r_amax : r_tgt);
                    r_state <= ST_M1;
                end
                ST_M1: r_state <= ST_R1;
                ST_R1: begin
                    r_nrate <= q_prod;
                    r_state <= ST_M2;
                end
                ST_M2: r_state <= ST_R2;
                ST_R2: begin
                    r_nrchg <= q_prod;
                    r_state <= ST_M3;
                end
                ST_M3: r_state <= ST_R3;
                ST_R3: begin
                    r_p2    <= q_prod;
                    r_state <= ST_D0;
                end
                ST_D0: r_state <= ST_D1;
                ST_D1: begin
                    r_qe    <= mul_p[32 +: DIVQ_W];
                    r_state <= ST_D2;
                end
                ST_D2: begin
                    // The remainder takes the sign of the angle.
                    r_red   <= r_nang[31] ? -$signed(32'(div_rem)) : $signed(32'(div_rem));
                    r_state <= ST_FOLD1;
                end
                ST_FOLD1: begin
                    r_red   <= fold1;
                    r_state <= ST_FOLD2;
                end
                ST_FOLD2: begin
                    r_red   <= fold2;
                    r_state <= ST_CS;
                end
                ST_CS: r_state <= ST_CW;
                ST_CW: begin
                    if (!cor_busy) begin
                        r_state <= ST_M4;
                    end
                end
                ST_M4: r_state <= ST_R4;
                ST_R4: begin
                    r_nacc  <= f_sat(-35'(q_prod) - 35'(r_p2) + 35'(r_frc));
                    r_state <= ST_M5;
                end
                ST_M5: r_state <= ST_R5;
                ST_R5: begin
                    r_nvel  <= f_sat(35'(q_prod) + 35'(r_vel));
                    r_state <= ST_M6;
                end
                ST_M6: r_state <= ST_R6;
                ST_R6: begin
                    r_pos   <= pin_pos;
                    r_vel   <= pin_vel;
                    r_acc   <= pin_acc;
                    r_ang   <= r_nang;
                    r_rate  <= r_nrate;
                    r_rchg  <= r_nrchg;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_o_pos     <= r_pos;
                        r_o_vel     <= r_vel;
                        r_o_acc     <= r_acc;
                        r_o_ang     <= r_ang;
                        r_o_rate    <= r_rate;
                        r_o_rchg    <= r_rchg;
                        r_o_failed  <= (r_pos <= r_lo) || (r_pos >= r_hi);
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.position    = r_o_pos;
    assign o_out.speed       = r_o_vel;
    assign o_out.accel       = r_o_acc;
    assign o_out.angle       = r_o_ang;
    assign o_out.angle_rate  = r_o_rate;
    assign o_out.angle_accel = r_o_rchg;
    assign o_out.failed      = r_o_failed;
endmodule

`default_nettype wire
